@@ sv/ctl_pkg.sv @@
package ctl_pkg;
    localparam int MAX_KNOTS     = 256;
    localparam int IDX_W         = 8;
    localparam int CNT_W         = 9;
    localparam int POS_W         = 17;
    localparam int CHAN_W        = 16;
    localparam int FRACTION_BITS = 16;
    localparam int FRAC_W        = FRACTION_BITS + 1;
    localparam logic [POS_W-1:0] ONE_POS = POS_W'(65536);
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;
    localparam logic [1:0] REG_KNOT_COUNT = 2'd0;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } color_t;

    // divider control between top level and divider unit
    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] num;
        logic [POS_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quot;
    } div_rsp_t;
endpackage

@@ sv/ctl_divider.sv @@
module ctl_divider import ctl_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int QW = POS_W + FRACTION_BITS;
    localparam int STEP_W = $clog2(QW + 1);

    logic [QW-1:0]     dividend_reg;
    logic [POS_W:0]    rem_reg;
    logic [POS_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [POS_W:0]    shifted;
    logic [POS_W:0]    diff;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg[POS_W-1:0], dividend_reg[QW-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg     <= 1'b1;
                step_reg     <= STEP_W'(QW);
                dividend_reg <= {req.num, {FRACTION_BITS{1'b0}}};
                rem_reg      <= '0;
                den_reg      <= req.den;
            end else if (busy_reg) begin
                if (!diff[POS_W]) begin
                    rem_reg <= diff;
                    dividend_reg <= {dividend_reg[QW-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    dividend_reg <= {dividend_reg[QW-2:0], 1'b0};
                end
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient is at most 2^16 when num <= den; clamp otherwise
    always_comb begin
        rsp.done = done_reg;
        if (dividend_reg[QW-1:FRAC_W] != '0
            || dividend_reg[FRAC_W-1:0] > FRAC_W'(1 << FRACTION_BITS))
            rsp.quot = FRAC_W'(1 << FRACTION_BITS);
        else
            rsp.quot = dividend_reg[FRAC_W-1:0];
    end
endmodule

@@ sv/color_transfer_lookup_lerp.sv @@
// lookup path: an empty table goes straight to the output, a sample at or beyond an end
// knot is clamped to it, an equal pair gives the upper knot, and interpolation runs the
// end-knot checks, up to 8 binary search probes and the 33-step divider; write items are
// stored on acceptance; one item at a time, after a lookup the next item is accepted the
// cycle after the result is taken; aresetn is synchronous active low and clears control
// state and knot_count, knot tables are not cleared and are undefined until written
module color_transfer_lookup_lerp import ctl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: operation, knot_index, knot_position, knot_red, knot_green,
    // knot_blue, sample_value (bits 0 .. 90), zero padded to 96
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: out_red, out_green, out_blue
    output logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [3:0] ST_IDLE = 4'd0, ST_RD0 = 4'd1, ST_CHK0 = 4'd2,
        ST_CHKN = 4'd3, ST_SRCH = 4'd4, ST_SRCHW = 4'd5, ST_PAIR0 = 4'd6,
        ST_PAIR1 = 4'd7, ST_DIV = 4'd8, ST_MUL = 4'd9, ST_SUM = 4'd10,
        ST_OUT = 4'd11, ST_RDN = 4'd12;
    localparam int PROD_W = CHAN_W + FRAC_W;
    localparam logic [FRAC_W-1:0] D_ONE = FRAC_W'(1 << FRACTION_BITS);

    logic [POS_W-1:0]  pos_mem [MAX_KNOTS];
    color_t            col_mem [MAX_KNOTS];
    logic [IDX_W-1:0]  rd_addr;
    logic [POS_W-1:0]  pos_rd;
    color_t            col_rd;

    logic [CNT_W-1:0]  count_reg;
    logic [3:0]        state_reg;
    logic [POS_W-1:0]  v_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  lo_reg, hi_reg;
    logic [IDX_W-1:0]  addr_reg;
    logic [POS_W-1:0]  s0_reg;
    color_t            c0_reg, c1_reg;
    logic [FRAC_W-1:0] d_reg;
    logic [PROD_W-1:0] pa_reg [3], pb_reg [3];
    logic [PROD_W-1:0] sum_w [3];
    color_t            out_reg;
    logic              out_valid_reg;
    div_req_t          dreq;
    div_rsp_t          drsp;

    logic              op;
    logic [IDX_W-1:0]  w_idx;
    logic [POS_W-1:0]  w_pos, samp;
    color_t            w_col;
    logic              accept;
    logic [CNT_W-1:0]  mid;

    assign op    = s_tdata[0];
    assign w_idx = s_tdata[8:1];
    assign w_pos = s_tdata[25:9];
    assign w_col = '{red: s_tdata[41:26], green: s_tdata[57:42], blue: s_tdata[73:58]};
    assign samp  = s_tdata[90:74];
    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept = s_tvalid && s_tready;
    assign mid = CNT_W'((lo_reg + hi_reg) >> 1);

    // knot memories, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (accept && op == OP_WRITE) begin
            pos_mem[w_idx] <= w_pos;
            col_mem[w_idx] <= w_col;
        end
        pos_rd <= pos_mem[rd_addr];
        col_rd <= col_mem[rd_addr];
    end

    always_comb begin
        case (state_reg)
            ST_SRCH: rd_addr = mid[IDX_W-1:0];
            default: rd_addr = addr_reg;
        endcase
    end

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_KNOT_COUNT) ? 32'(count_reg) : 32'd0;

    assign dreq.start = (state_reg == ST_PAIR1) && (pos_rd > s0_reg);
    assign dreq.num   = (v_reg > s0_reg) ? v_reg - s0_reg : '0;
    assign dreq.den   = pos_rd - s0_reg;

    ctl_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // blend sums, at most 2^32 - 2^16
    assign sum_w[0] = pa_reg[0] + pb_reg[0];
    assign sum_w[1] = pa_reg[1] + pb_reg[1];
    assign sum_w[2] = pa_reg[2] + pb_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == REG_KNOT_COUNT)
                count_reg <= pwdata[CNT_W-1:0];
            if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (accept && op == OP_LOOKUP) begin
                        v_reg <= (samp > ONE_POS) ? ONE_POS : samp;
                        n_reg <= (count_reg > CNT_W'(MAX_KNOTS)) ? CNT_W'(MAX_KNOTS)
                                                                 : count_reg;
                        addr_reg <= '0;
                        if (count_reg == '0) begin
                            out_reg <= '0;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_RD0;
                        end
                    end
                end
                ST_RD0: begin
                    addr_reg  <= IDX_W'(n_reg - 1'b1);
                    state_reg <= ST_CHK0;
                end
                ST_CHK0: begin
                    // pos_rd is entry 0
                    s0_reg <= pos_rd;
                    if (v_reg <= pos_rd) begin
                        out_reg <= col_rd;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_CHKN;
                    end
                end
                ST_CHKN: begin
                    // pos_rd is last entry
                    if (v_reg >= pos_rd) begin
                        out_reg <= col_rd;
                        state_reg <= ST_OUT;
                    end else begin
                        lo_reg <= CNT_W'(1);
                        hi_reg <= n_reg - 1'b1;
                        state_reg <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    if (lo_reg >= hi_reg) begin
                        addr_reg  <= IDX_W'(hi_reg - 1'b1);
                        state_reg <= ST_PAIR0;
                    end else begin
                        state_reg <= ST_SRCHW;
                    end
                end
                ST_SRCHW: begin
                    // lowest i with pos >= v, on memory in lower half search
                    if (pos_rd >= v_reg) hi_reg <= mid;
                    else lo_reg <= mid + 1'b1;
                    state_reg <= ST_SRCH;
                end
                ST_PAIR0: begin
                    addr_reg  <= IDX_W'(hi_reg);
                    state_reg <= ST_RDN;
                end
                ST_RDN: begin
                    s0_reg <= pos_rd;
                    c0_reg <= col_rd;
                    state_reg <= ST_PAIR1;
                end
                ST_PAIR1: begin
                    c1_reg <= col_rd;
                    if (pos_rd <= s0_reg) begin
                        out_reg <= col_rd;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (drsp.done) begin
                        d_reg <= drsp.quot;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    pa_reg[0] <= PROD_W'(c0_reg.red) * PROD_W'(D_ONE - d_reg);
                    pa_reg[1] <= PROD_W'(c0_reg.green) * PROD_W'(D_ONE - d_reg);
                    pa_reg[2] <= PROD_W'(c0_reg.blue) * PROD_W'(D_ONE - d_reg);
                    pb_reg[0] <= PROD_W'(c1_reg.red) * PROD_W'(d_reg);
                    pb_reg[1] <= PROD_W'(c1_reg.green) * PROD_W'(d_reg);
                    pb_reg[2] <= PROD_W'(c1_reg.blue) * PROD_W'(d_reg);
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    out_reg.red   <= sum_w[0][FRACTION_BITS +: CHAN_W];
                    out_reg.green <= sum_w[1][FRACTION_BITS +: CHAN_W];
                    out_reg.blue  <= sum_w[2][FRACTION_BITS +: CHAN_W];
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.blue, out_reg.green, out_reg.red};

    // no input accepted while a result waits
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
    // result appears only from output state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_OUT) else $error("stray result");
    // divider done only while waiting for it
    a_div: assert property (@(posedge aclk) disable iff (!aresetn)
        drsp.done |-> state_reg == ST_DIV) else $error("divider out of step");
endmodule
